// File: design/vehicle_link_supervisor_fsm_macros.svh
// Assertion macros for the vehicle link supervisor.
`ifndef VEHICLE_LINK_SUPERVISOR_FSM_MACROS_SVH
`define VEHICLE_LINK_SUPERVISOR_FSM_MACROS_SVH

`ifndef SYNTHESIS
`define VLS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vls assertion failed");
`define VLS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vls assertion failed");
`else
`define VLS_ASSERT(lbl, cond)
`define VLS_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: design/vls_pkg.sv
// Types, codes and helpers for the vehicle link supervisor.
package vls_pkg;

    localparam int TIMER_BITS = 24;
    localparam int CFG_W      = 24;

    localparam logic [CFG_W-1:0] IDLE_TO_RST    = CFG_W'(300000);
    localparam logic [CFG_W-1:0] LOST_TO_RST    = CFG_W'(60000);
    localparam logic [CFG_W-1:0] CONFIRM_TO_RST = CFG_W'(5000);

    localparam logic [1:0] CFG_IDLE    = 2'd0;
    localparam logic [1:0] CFG_LOST    = 2'd1;
    localparam logic [1:0] CFG_CONFIRM = 2'd2;

    // mode codes as seen on the port and in partner packets
    localparam logic [2:0] CODE_BOOT    = 3'd0;
    localparam logic [2:0] CODE_NORMAL  = 3'd1;
    localparam logic [2:0] CODE_LINKERR = 3'd2;
    localparam logic [2:0] CODE_ESTOP   = 3'd3;
    localparam logic [2:0] CODE_IDLE    = 3'd4;
    localparam logic [2:0] CODE_OFF     = 3'd5;

    localparam logic [1:0] LINK_OK     = 2'd0;
    localparam logic [1:0] LINK_LOST   = 2'd1;
    localparam logic [1:0] LINK_NOADDR = 2'd2;

    localparam logic [1:0] STOP_NONE   = 2'd0;
    localparam logic [1:0] STOP_SAFETY = 2'd1;
    localparam logic [1:0] STOP_EMERG  = 2'd2;

    typedef enum logic [5:0] {
        MODE_BOOT    = 6'b000001,
        MODE_NORMAL  = 6'b000010,
        MODE_LINKERR = 6'b000100,
        MODE_ESTOP   = 6'b001000,
        MODE_IDLE    = 6'b010000,
        MODE_OFF     = 6'b100000
    } mode_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        case (m)
            MODE_BOOT:    c = CODE_BOOT;
            MODE_NORMAL:  c = CODE_NORMAL;
            MODE_LINKERR: c = CODE_LINKERR;
            MODE_ESTOP:   c = CODE_ESTOP;
            MODE_IDLE:    c = CODE_IDLE;
            MODE_OFF:     c = CODE_OFF;
            default:      c = CODE_BOOT;
        endcase
        return c;
    endfunction

    // saturating timer advance
    function automatic logic [TIMER_BITS-1:0] timer_add(input logic [TIMER_BITS-1:0] c,
                                                        input logic [7:0] e);
        logic [TIMER_BITS:0] s;
        s = {1'b0, c} + (TIMER_BITS+1)'(e);
        return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
    endfunction

    function automatic logic timer_done(input logic [TIMER_BITS-1:0] c,
                                        input logic [CFG_W-1:0] lim);
        return 32'(c) >= 32'(lim);
    endfunction

endpackage

// File: design/vehicle_link_supervisor_fsm.sv
// Top level of the vehicle link supervisor: mode control, timers and power sequencing.
//
// Vehicle link supervisor. One input beat is one control-loop pass and yields exactly
// one result beat. A pass is captured in an input register, then combinational logic
// updates the mode, timers and latches and loads the result register, so one pass is
// taken every cycle unless the result side stalls. The result register holds while it is
// full and result_stall is high, and a full input register holds with it; the input side
// stalls only when both are full. Configuration writes (cfg_we, cfg_index, cfg_data) take effect
// at the next edge; the user must make them only while no pass is in flight (not checked).
`include "vehicle_link_supervisor_fsm_macros.svh"

module vehicle_link_supervisor_fsm import vls_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,

    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [7:0]              elapsed_ms,
    input  logic                    estop_pressed,
    input  logic [1:0]              link_status,
    input  logic                    packet_valid,
    input  logic [2:0]              partner_mode,
    input  logic signed [15:0]      throttle_in,
    input  logic signed [15:0]      steering_in,

    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [2:0]              mode,
    output logic signed [15:0]      drive_throttle,
    output logic signed [15:0]      drive_steering,
    output logic [1:0]              motor_stop,
    output logic                    system_power,
    output logic                    board_power_off
);

    // configuration
    logic [CFG_W-1:0] idle_to_reg, lost_to_reg, confirm_to_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_to_reg    <= IDLE_TO_RST;
            lost_to_reg    <= LOST_TO_RST;
            confirm_to_reg <= CONFIRM_TO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE:    idle_to_reg    <= cfg_data;
                CFG_LOST:    lost_to_reg    <= cfg_data;
                CFG_CONFIRM: confirm_to_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // pipeline control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s2_load;
    logic s1_load;
    logic step_en;

    assign s2_load    = !(out_valid_reg && result_stall);
    assign item_stall = s1_valid_reg && !s2_load;
    assign s1_load    = item_valid && !item_stall;
    assign step_en    = s1_valid_reg && s2_load;

    // input register
    logic [7:0]  s1_elapsed_reg;
    logic        s1_estop_reg;
    logic [1:0]  s1_link_reg;
    logic        s1_pvalid_reg;
    logic [2:0]  s1_pmode_reg;
    logic [15:0] s1_thr_reg;
    logic [15:0] s1_str_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (step_en)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_elapsed_reg <= elapsed_ms;
            s1_estop_reg   <= estop_pressed;
            s1_link_reg    <= link_status;
            s1_pvalid_reg  <= packet_valid;
            s1_pmode_reg   <= partner_mode;
            s1_thr_reg     <= throttle_in;
            s1_str_reg     <= steering_in;
        end
    end

    // supervisor state
    mode_t                 mode_reg, mode_next;
    logic [2:0]            pmode_reg, pmode_next;
    logic                  ready_reg, ready_next;
    logic                  orun_reg, orun_next;
    logic [TIMER_BITS-1:0] ocnt_reg, ocnt_next;
    logic [CFG_W-1:0]      olim_reg, olim_next;
    logic                  crun_reg, crun_next;
    logic [TIMER_BITS-1:0] ccnt_reg, ccnt_next;
    logic [31:0]           drv_reg, drv_next;
    logic [1:0]            stop_reg, stop_next;
    logic                  spwr_reg, spwr_next;
    logic                  boff_reg, boff_next;

    always_comb
    begin
        mode_next  = mode_reg;
        pmode_next = pmode_reg;
        ready_next = ready_reg;
        orun_next  = orun_reg;
        ocnt_next  = ocnt_reg;
        olim_next  = olim_reg;
        crun_next  = crun_reg;
        ccnt_next  = ccnt_reg;
        drv_next   = drv_reg;
        stop_next  = stop_reg;
        spwr_next  = spwr_reg;
        boff_next  = boff_reg;

        if (orun_next)
            ocnt_next = timer_add(ocnt_next, s1_elapsed_reg);
        if (crun_next)
            ccnt_next = timer_add(ccnt_next, s1_elapsed_reg);

        if (s1_pvalid_reg)
        begin
            pmode_next = s1_pmode_reg;
            drv_next   = (mode_reg == MODE_NORMAL) ? {s1_str_reg, s1_thr_reg} : 32'd0;
        end

        // transitions
        if (mode_next != MODE_OFF)
        begin
            if (orun_next && timer_done(ocnt_next, olim_next))
                mode_next = MODE_OFF;
            else if (mode_next == MODE_BOOT)
            begin
                if (s1_link_reg == LINK_OK && ready_next)
                    mode_next = MODE_NORMAL;
            end
            else if (s1_estop_reg || pmode_next == CODE_ESTOP)
                mode_next = MODE_ESTOP;
            else
            begin
                // leaving e-stop restores power and clears the stop latch
                if (mode_next == MODE_ESTOP)
                begin
                    mode_next = MODE_NORMAL;
                    spwr_next = 1'b1;
                    stop_next = STOP_NONE;
                    orun_next = 1'b0;
                end
                if (s1_link_reg != LINK_OK)
                    mode_next = MODE_LINKERR;
                else if (pmode_next == CODE_IDLE)
                    mode_next = MODE_IDLE;
                else if (pmode_next == CODE_OFF)
                begin
                    if (mode_next == MODE_IDLE)
                        mode_next = MODE_OFF;
                end
                else if (pmode_next == CODE_NORMAL)
                    mode_next = MODE_NORMAL;
            end
        end

        // mode actions
        case (mode_next)
            MODE_BOOT:
            begin
                if (!orun_next)
                begin
                    orun_next = 1'b1;
                    ocnt_next = '0;
                    olim_next = idle_to_reg;
                end
                if (s1_link_reg != LINK_NOADDR)
                    ready_next = 1'b1;
            end
            MODE_NORMAL:
            begin
                orun_next = 1'b0;
                stop_next = STOP_NONE;
            end
            MODE_LINKERR:
            begin
                if (s1_link_reg == LINK_LOST && !orun_next)
                begin
                    orun_next = 1'b1;
                    ocnt_next = '0;
                    olim_next = lost_to_reg;
                end
                stop_next = STOP_SAFETY;
                drv_next  = 32'd0;
            end
            MODE_ESTOP:
            begin
                stop_next = STOP_EMERG;
                if (!orun_next)
                begin
                    orun_next = 1'b1;
                    ocnt_next = '0;
                    olim_next = idle_to_reg;
                end
            end
            MODE_IDLE:
            begin
                // restart with the idle interval unless already running on it
                if (!orun_next || olim_next != idle_to_reg)
                begin
                    orun_next = 1'b1;
                    ocnt_next = '0;
                    olim_next = idle_to_reg;
                end
            end
            MODE_OFF:
            begin
                stop_next = STOP_EMERG;
                orun_next = 1'b0;
                if (!crun_next)
                begin
                    crun_next = 1'b1;
                    ccnt_next = '0;
                end
                if (pmode_next == CODE_OFF || timer_done(ccnt_next, confirm_to_reg))
                begin
                    spwr_next = 1'b0;
                    boff_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BOOT;
            pmode_reg <= CODE_BOOT;
            ready_reg <= 1'b0;
            orun_reg  <= 1'b0;
            ocnt_reg  <= '0;
            olim_reg  <= IDLE_TO_RST;
            crun_reg  <= 1'b0;
            ccnt_reg  <= '0;
            drv_reg   <= 32'd0;
            stop_reg  <= STOP_NONE;
            spwr_reg  <= 1'b1;
            boff_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            pmode_reg <= pmode_next;
            ready_reg <= ready_next;
            orun_reg  <= orun_next;
            ocnt_reg  <= ocnt_next;
            olim_reg  <= olim_next;
            crun_reg  <= crun_next;
            ccnt_reg  <= ccnt_next;
            drv_reg   <= drv_next;
            stop_reg  <= stop_next;
            spwr_reg  <= spwr_next;
            boff_reg  <= boff_next;
        end
    end

    // result register
    logic [2:0]  out_mode_reg;
    logic [15:0] out_thr_reg, out_str_reg;
    logic [1:0]  out_stop_reg;
    logic        out_spwr_reg, out_boff_reg;
    logic        drive_en;

    assign drive_en = (mode_next == MODE_NORMAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_load)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_mode_reg <= mode_code(mode_next);
            out_thr_reg  <= drive_en ? drv_next[15:0]  : 16'd0;
            out_str_reg  <= drive_en ? drv_next[31:16] : 16'd0;
            out_stop_reg <= stop_next;
            out_spwr_reg <= spwr_next;
            out_boff_reg <= boff_next;
        end
    end

    assign result_valid    = out_valid_reg;
    assign mode            = out_mode_reg;
    assign drive_throttle  = out_thr_reg;
    assign drive_steering  = out_str_reg;
    assign motor_stop      = out_stop_reg;
    assign system_power    = out_spwr_reg;
    assign board_power_off = out_boff_reg;

    // board power cut is sticky and always comes with system power off
    `VLS_ASSERT_NEXT(a_boff_sticky, boff_reg, boff_reg)
    `VLS_ASSERT(a_boff_no_power, !boff_reg || !spwr_reg)
    `VLS_ASSERT(a_drive_neutral, !(out_valid_reg && out_mode_reg != CODE_NORMAL) || (out_thr_reg == 16'd0 && out_str_reg == 16'd0))
    `VLS_ASSERT(a_off_emerg, !(out_valid_reg && out_mode_reg == CODE_OFF) || out_stop_reg == STOP_EMERG)
    `VLS_ASSERT(a_stall_full, !item_stall || (s1_valid_reg && out_valid_reg))

endmodule
